FILE: rtl/core/bukt_pkg.sv
// Shared constants, command codes and controller/datapath structs for the
// bounded unique-key table. Depends on nothing.
package bukt_pkg;

   localparam int DEPTH = 16;
   localparam int KEY_W = 32;
   localparam int PAY_W = 32;
   localparam int CMD_W = 2;
   localparam int CNT_W = 5;
   localparam int IDX_W = $clog2(DEPTH);

   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic [CNT_W-1:0] CAP_RESET  = 5'd16;

   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } dp_status_type;

endpackage

FILE: rtl/core/bukt_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on bukt_pkg for field widths.
interface bukt_req_if;
   logic                        valid;
   logic                        ready;
   logic [bukt_pkg::CMD_W-1:0]  cmd;
   logic [bukt_pkg::KEY_W-1:0]  key;
   logic [bukt_pkg::PAY_W-1:0]  payload;

   modport source (output valid, output cmd, output key, output payload, input ready);
   modport sink (input valid, input cmd, input key, input payload, output ready);
endinterface

interface bukt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        accepted;
   logic                        found;
   logic [bukt_pkg::PAY_W-1:0]  found_payload;
   logic [bukt_pkg::CNT_W-1:0]  entry_total;

   modport source (output valid, output accepted, output found, output found_payload,
                   output entry_total, input ready);
   modport sink (input valid, input accepted, input found, input found_payload,
                 input entry_total, output ready);
endinterface

FILE: rtl/core/bukt_ctrl.sv
// Sequencing state machine of the key table: accept, scan, commit.
// Depends on bukt_pkg for the command and status structs.
module bukt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bukt_pkg::dp_status_type status,
   output bukt_pkg::ctrl_cmd_type  ctrl
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      ctrl.start  = 1'b0;
      ctrl.scan   = 1'b0;
      ctrl.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.start = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctrl.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold the finished word until the response register can take it.
            if (status.out_free) begin
               ctrl.commit = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/bukt_dp.sv
// Datapath of the key table: entry storage, sequential key scan, entry
// count, capacity register and response register. Depends on bukt_pkg.
module bukt_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [bukt_pkg::CNT_W-1:0]   csr_wr_data,
   input  logic [bukt_pkg::CMD_W-1:0]   req_cmd,
   input  logic [bukt_pkg::KEY_W-1:0]   req_key,
   input  logic [bukt_pkg::PAY_W-1:0]   req_payload,
   input  bukt_pkg::ctrl_cmd_type       ctrl,
   output bukt_pkg::dp_status_type      status,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic                         rsp_accepted,
   output logic                         rsp_found,
   output logic [bukt_pkg::PAY_W-1:0]   rsp_found_payload,
   output logic [bukt_pkg::CNT_W-1:0]   rsp_entry_total
);

   localparam logic [bukt_pkg::CNT_W-1:0] DEPTH_CNT = bukt_pkg::CNT_W'(bukt_pkg::DEPTH);

   logic [bukt_pkg::KEY_W-1:0] key_mem [bukt_pkg::DEPTH];
   logic [bukt_pkg::PAY_W-1:0] pay_mem [bukt_pkg::DEPTH];

   logic [bukt_pkg::CNT_W-1:0] cap_ff;
   logic [bukt_pkg::CNT_W-1:0] count_ff, count_in;
   logic [bukt_pkg::CMD_W-1:0] cmd_ff;
   logic [bukt_pkg::KEY_W-1:0] key_ff;
   logic [bukt_pkg::PAY_W-1:0] pay_ff;
   logic [bukt_pkg::CNT_W-1:0] issue_ff, issue_in;
   logic                       cmp_valid_ff, cmp_valid_in;
   logic                       hit_ff, hit_in;
   logic [bukt_pkg::PAY_W-1:0] hit_pay_ff, hit_pay_in;
   logic [bukt_pkg::KEY_W-1:0] rd_key_ff;
   logic [bukt_pkg::PAY_W-1:0] rd_pay_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_acc_ff;
   logic                       rsp_found_ff;
   logic [bukt_pkg::PAY_W-1:0] rsp_pay_ff;
   logic [bukt_pkg::CNT_W-1:0] rsp_total_ff;

   logic                       is_add;
   logic                       is_clear;
   logic [bukt_pkg::CNT_W-1:0] limit;
   logic                       take;
   logic                       issue_go;

   assign is_add   = (cmd_ff == bukt_pkg::CMD_ADD);
   assign is_clear = (cmd_ff == bukt_pkg::CMD_CLEAR);
   assign limit    = (cap_ff > DEPTH_CNT) ? DEPTH_CNT : cap_ff;
   assign take     = is_add && (count_ff < limit) && !hit_ff;
   assign issue_go = ctrl.scan && !hit_ff && (issue_ff < count_ff);

   // One read is issued per cycle; its compare happens the cycle after.
   always_comb begin
      issue_in     = issue_ff;
      cmp_valid_in = 1'b0;
      hit_in       = hit_ff;
      hit_pay_in   = hit_pay_ff;
      if (ctrl.start) begin
         issue_in   = '0;
         hit_in     = 1'b0;
         hit_pay_in = '0;
      end else if (ctrl.scan) begin
         if (issue_go) begin
            issue_in     = issue_ff + 1'b1;
            cmp_valid_in = 1'b1;
         end
         if (cmp_valid_ff && !hit_ff && (rd_key_ff == key_ff)) begin
            hit_in     = 1'b1;
            hit_pay_in = rd_pay_ff;
         end
      end
   end

   assign status.scan_done = is_clear || hit_ff || ((issue_ff >= count_ff) && !cmp_valid_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (ctrl.commit) begin
         if (is_clear) begin
            count_in = '0;
         end else if (take) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit && take) begin
         key_mem[count_ff[bukt_pkg::IDX_W-1:0]] <= key_ff;
         pay_mem[count_ff[bukt_pkg::IDX_W-1:0]] <= pay_ff;
      end
      rd_key_ff <= key_mem[issue_ff[bukt_pkg::IDX_W-1:0]];
      rd_pay_ff <= pay_mem[issue_ff[bukt_pkg::IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= bukt_pkg::CAP_RESET;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff   <= issue_in;
      hit_pay_ff <= hit_pay_in;
      if (ctrl.start) begin
         cmd_ff <= req_cmd;
         key_ff <= req_key;
         pay_ff <= req_payload;
      end
      if (ctrl.commit) begin
         rsp_acc_ff   <= take;
         rsp_found_ff <= hit_ff;
         rsp_pay_ff   <= hit_pay_ff;
         rsp_total_ff <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_found_payload = rsp_pay_ff;
   assign rsp_entry_total   = rsp_total_ff;

endmodule

FILE: rtl/core/bounded_unique_key_table.sv
// Bounded unique-key table: one request word at a time; a lookup or add walks the
// filled entries of the entry store one entry per cycle and stops early on a match,
// while a clear does not wait on the scan. The next request is taken the cycle after
// the response is loaded; a stalled response side holds the block until the response
// register is free. Reset (synchronous, active high) empties the table and sets the
// capacity to 16.
module bounded_unique_key_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [bukt_pkg::CNT_W-1:0]  csr_wr_data,
   bukt_req_if.sink                    req_bus,
   bukt_rsp_if.source                  rsp_bus
);

   // Command and status bundles between the sequencer and the datapath.
   bukt_pkg::ctrl_cmd_type  ctrl;
   bukt_pkg::dp_status_type status;

   // The sequencer only accepts a word when idle; the scan then walks the
   // filled slots from slot zero upward and stops early on a match.
   bukt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   // The datapath owns the entry store and a response register, so a finished
   // word can wait on the response side while the next request is accepted.
   bukt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_cmd           (req_bus.cmd),
      .req_key           (req_bus.key),
      .req_payload       (req_bus.payload),
      .ctrl              (ctrl),
      .status            (status),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_accepted      (rsp_bus.accepted),
      .rsp_found         (rsp_bus.found),
      .rsp_found_payload (rsp_bus.found_payload),
      .rsp_entry_total   (rsp_bus.entry_total)
   );

`ifndef SYNTHESIS
   // A stored add never reports its key as already present.
   a_acc_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.accepted && rsp_bus.found))
      else $error("add reported both stored and duplicate");

   // A successful add always leaves at least one entry.
   a_acc_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.accepted) |-> (rsp_bus.entry_total != '0))
      else $error("accepted add with empty table");

   // A miss carries a zero payload.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.found) |-> (rsp_bus.found_payload == '0))
      else $error("payload nonzero on miss");

   // Only one request is in work at a time.
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while another is in work");
`endif

endmodule
